[sv/dee_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the decimal expression evaluator.
// Payload structs, controller/datapath command and status, power-of-ten table.
package dee_pkg;

  localparam int VAL_W = 40;
  localparam int RES_W = 48;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_PLUS  = 3'd1;
  localparam logic [2:0] OP_MINUS = 3'd2;
  localparam logic [2:0] OP_TIMES = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] DS_FRAC1 = 2'd0;
  localparam logic [1:0] DS_FRAC2 = 2'd1;
  localparam logic [1:0] DS_OPER  = 2'd2;

  localparam logic [39:0] DIVIDE_MIN_RST = 40'd655;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]        first_value;
    logic [VAL_W-1:0]        second_value;
    logic signed [RES_W-1:0] result_value;
    logic [2:0]              operator_code;
    logic                    parse_error;
    logic                    divide_blocked;
  } out_t;

  typedef struct packed {
    logic       take;
    logic       start_div;
    logic [1:0] div_src;
    logic       load_frac1;
    logic       load_frac2;
    logic       start_mul;
    logic       load_op;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic need_div;
    logic need_mul;
    logic div_done;
    logic mul_done;
    logic out_free;
  } stat_t;

  function automatic logic [23:0] pow_ten(input logic [2:0] n);
    logic [23:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

[sv/decimal_expression_evaluator.sv]
`timescale 1ns / 1ps
// Decimal expression evaluator. Characters transfer one per cycle while the controller is idle;
// the last one stalls input through two fraction scalings on the shared bit-serial divider of width
// DW = max(INT_BITS+2*FRAC_BITS, 4*MAX_FRAC_DIGITS+FRAC_BITS), a dispatch step, a divide or multiply
// where one is needed, and the output load, which waits while the result register stays stalled;
// a parse error skips straight to the load. The result is valid in the cycle after the load.
// Synchronous active-low reset clears the parser and sets divide_min to 655.
module decimal_expression_evaluator #(
  parameter int INT_BITS        = 24,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dee_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dee_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [39:0]   cfg_wdata
);
  import dee_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_char),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  dee_dpath #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sv/dee_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the datapath for fraction scaling and the divide operation.
module dee_div #(
  parameter int DW  = 56,
  parameter int DVW = 40
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [DW-1:0]  quotient
);

  localparam int CW = $clog2(DW);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] b_r;
  logic [DW-1:0]  q_r;

  logic [DVW:0]   rem_sh;
  logic [DVW:0]   diff;
  logic           ge;
  logic [DVW-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, q_r[DW-1]};
    ge      = rem_sh >= {1'b0, b_r};
    diff    = rem_sh - {1'b0, b_r};
    rem_nxt = ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        b_r    <= divisor;
        q_r    <= dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[DW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[sv/dee_dpath.sv]
`timescale 1ns / 1ps
// Datapath: character parser registers, shared divider, serial multiplier,
// result assembly and output register. Depends on dee_pkg and dee_div.
module dee_dpath #(
  parameter int INT_BITS        = 24,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dee_pkg::in_t  in_data,
  input  logic          cfg_we,
  input  logic [39:0]   cfg_wdata,
  input  dee_pkg::cmd_t cmd,
  output dee_pkg::stat_t stat,
  input  logic          out_stall,
  output logic          out_valid,
  output dee_pkg::out_t out_data
);
  import dee_pkg::*;

  localparam int W      = INT_BITS + FRAC_BITS;
  localparam int FACC_W = 4 * MAX_FRAC_DIGITS;
  localparam int CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int DW     = (W + FRAC_BITS > FACC_W + FRAC_BITS) ? W + FRAC_BITS
                                                               : FACC_W + FRAC_BITS;
  localparam int DVW    = (W > FACC_W) ? W : FACC_W;
  localparam int PW     = 2 * W;
  localparam int MCW    = $clog2(W);
  localparam int SW     = ((W > RES_W) ? W : RES_W) + 2;
  localparam int CMW    = (W > VAL_W) ? W : VAL_W;

  // parser state
  logic                in_sec_r, in_sec_nxt;
  logic [2:0]          op_r, op_nxt;
  logic                dot_r, dot_nxt;
  logic [INT_BITS-1:0] int_r, int_nxt;
  logic [FACC_W-1:0]   facc_r, facc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [INT_BITS-1:0] sint_r, sint_nxt;
  logic [FACC_W-1:0]   sfacc_r, sfacc_nxt;
  logic [CNT_W-1:0]    scnt_r, scnt_nxt;
  logic                empty_r, empty_nxt;
  logic                err_r, err_nxt;

  logic [FRAC_BITS-1:0] frac1_r;
  logic [FRAC_BITS-1:0] frac2_r;
  logic [39:0]          dmin_r;
  logic [RES_W-1:0]     opres_r;

  logic                 out_valid_r;
  out_t                 out_r, out_nxt;

  logic [7:0]           ch;
  logic [3:0]           dgt;
  logic [2:0]           op_dec;
  logic [INT_BITS+3:0]  int_mac;
  logic [FACC_W+3:0]    facc_mac;

  assign ch  = in_data.char_code;
  assign dgt = 4'(ch - CH_ZERO);

  always_comb begin
    case (ch)
      CH_PLUS:  op_dec = OP_PLUS;
      CH_MINUS: op_dec = OP_MINUS;
      CH_TIMES: op_dec = OP_TIMES;
      CH_SLASH: op_dec = OP_DIV;
      default:  op_dec = OP_NONE;
    endcase
  end

  always_comb begin
    in_sec_nxt = in_sec_r;
    op_nxt     = op_r;
    dot_nxt    = dot_r;
    int_nxt    = int_r;
    facc_nxt   = facc_r;
    cnt_nxt    = cnt_r;
    sint_nxt   = sint_r;
    sfacc_nxt  = sfacc_r;
    scnt_nxt   = scnt_r;
    empty_nxt  = empty_r;
    err_nxt    = err_r;
    int_mac    = (INT_BITS + 4)'(int_r) * 4'd10 + (INT_BITS + 4)'(dgt);
    facc_mac   = (FACC_W + 4)'(facc_r) * 4'd10 + (FACC_W + 4)'(dgt);
    if (ch inside {[CH_ZERO:CH_NINE]}) begin
      if (!in_sec_r) empty_nxt = 1'b0;
      if (dot_r) begin
        if (cnt_r < CNT_W'(MAX_FRAC_DIGITS)) begin
          facc_nxt = facc_mac[FACC_W-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
      end else if (|int_mac[INT_BITS+3:INT_BITS]) begin
        int_nxt = '1;
      end else begin
        int_nxt = int_mac[INT_BITS-1:0];
      end
    end else if (ch == CH_DOT) begin
      if (!in_sec_r) empty_nxt = 1'b0;
      if (dot_r) err_nxt = 1'b1;
      else dot_nxt = 1'b1;
    end else if (op_dec == OP_NONE || in_sec_r) begin
      err_nxt = 1'b1;
    end else begin
      sint_nxt   = int_r;
      sfacc_nxt  = facc_r;
      scnt_nxt   = cnt_r;
      op_nxt     = op_dec;
      in_sec_nxt = 1'b1;
      dot_nxt    = 1'b0;
      int_nxt    = '0;
      facc_nxt   = '0;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      in_sec_r <= 1'b0;
      op_r     <= OP_NONE;
      dot_r    <= 1'b0;
      int_r    <= '0;
      facc_r   <= '0;
      cnt_r    <= '0;
      sint_r   <= '0;
      sfacc_r  <= '0;
      scnt_r   <= '0;
      empty_r  <= 1'b1;
      err_r    <= 1'b0;
    end else if (cmd.take && !err_r) begin
      in_sec_r <= in_sec_nxt;
      op_r     <= op_nxt;
      dot_r    <= dot_nxt;
      int_r    <= int_nxt;
      facc_r   <= facc_nxt;
      cnt_r    <= cnt_nxt;
      sint_r   <= sint_nxt;
      sfacc_r  <= sfacc_nxt;
      scnt_r   <= scnt_nxt;
      empty_r  <= empty_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dmin_r <= DIVIDE_MIN_RST;
    else if (cfg_we) dmin_r <= cfg_wdata;
  end

  // operand values
  logic [W-1:0] sav_val;
  logic [W-1:0] cur_val;
  assign sav_val = {sint_r, frac1_r};
  assign cur_val = {int_r, frac2_r};

  // shared divider
  logic [DW-1:0]  div_a;
  logic [DVW-1:0] div_b;
  logic           div_done;
  logic [DW-1:0]  div_q;

  always_comb begin
    case (cmd.div_src)
      DS_FRAC1: begin
        div_a = DW'({sfacc_r, {FRAC_BITS{1'b0}}});
        div_b = DVW'(pow_ten(3'(scnt_r)));
      end
      DS_FRAC2: begin
        div_a = DW'({facc_r, {FRAC_BITS{1'b0}}});
        div_b = DVW'(pow_ten(3'(cnt_r)));
      end
      default: begin
        div_a = DW'({sav_val, {FRAC_BITS{1'b0}}});
        div_b = DVW'(cur_val);
      end
    endcase
  end

  dee_div #(.DW(DW), .DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_div),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_frac1) frac1_r <= div_q[FRAC_BITS-1:0];
    if (cmd.load_frac2) frac2_r <= div_q[FRAC_BITS-1:0];
  end

  // shift-add multiplier, one multiplier bit per cycle
  logic          mbusy_r, mdone_r;
  logic [MCW-1:0] mcnt_r;
  logic [PW-1:0] mcand_r, prod_r;
  logic [W-1:0]  mplier_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
      mcnt_r  <= '0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.start_mul) begin
        mbusy_r  <= 1'b1;
        mcnt_r   <= '0;
        mcand_r  <= PW'(sav_val);
        mplier_r <= cur_val;
        prod_r   <= '0;
      end else if (mbusy_r) begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r  <= {mcand_r[PW-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[W-1:1]};
        mcnt_r   <= mcnt_r + 1'b1;
        if (mcnt_r == MCW'(W - 1)) begin
          mbusy_r <= 1'b0;
          mdone_r <= 1'b1;
        end
      end
    end
  end

  // saturation of product and quotient
  logic [PW+RES_W-1:0] p_sh;
  logic [DW+RES_W-1:0] q_ext;
  logic [RES_W-1:0]    mul_sat, div_sat;
  localparam logic [RES_W-1:0] RMAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RMIN = {1'b1, {(RES_W-1){1'b0}}};

  always_comb begin
    p_sh    = {{RES_W{1'b0}}, prod_r} >> FRAC_BITS;
    mul_sat = (|p_sh[PW+RES_W-1:RES_W-1]) ? RMAX : p_sh[RES_W-1:0];
    q_ext   = {{RES_W{1'b0}}, div_q};
    div_sat = (|q_ext[DW+RES_W-1:RES_W-1]) ? RMAX : q_ext[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) opres_r <= (op_r == OP_TIMES) ? mul_sat : div_sat;
  end

  // final assembly
  logic            blocked;
  logic [SW-1:0]   sum;
  logic [RES_W-1:0] sum_sat;
  logic [W+RES_W-1:0] cur_ext, sav_ext;

  always_comb begin
    blocked = CMW'(cur_val) <= CMW'(dmin_r);
    sum     = (op_r == OP_PLUS) ? SW'(sav_val) + SW'(cur_val) : SW'(sav_val) - SW'(cur_val);
    if ((&sum[SW-1:RES_W-1]) || !(|sum[SW-1:RES_W-1])) sum_sat = sum[RES_W-1:0];
    else sum_sat = sum[SW-1] ? RMIN : RMAX;
    cur_ext = {{RES_W{1'b0}}, cur_val};
    sav_ext = {{RES_W{1'b0}}, sav_val};

    out_nxt                = '0;
    out_nxt.operator_code  = op_r;
    out_nxt.parse_error    = err_r;
    if (!err_r) begin
      if (op_r == OP_NONE) begin
        out_nxt.first_value  = cur_ext[VAL_W-1:0];
        out_nxt.result_value = cur_ext[RES_W-1:0];
      end else if (empty_r) begin
        out_nxt.second_value = cur_ext[VAL_W-1:0];
        out_nxt.result_value = cur_ext[RES_W-1:0];
      end else begin
        out_nxt.first_value  = sav_ext[VAL_W-1:0];
        out_nxt.second_value = cur_ext[VAL_W-1:0];
        case (op_r)
          OP_PLUS, OP_MINUS: out_nxt.result_value = sum_sat;
          OP_TIMES:          out_nxt.result_value = opres_r;
          default: begin
            out_nxt.result_value   = blocked ? '0 : opres_r;
            out_nxt.divide_blocked = blocked;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stat.err      = err_r;
    stat.need_mul = !err_r && !empty_r && op_r == OP_TIMES;
    stat.need_div = !err_r && !empty_r && op_r == OP_DIV && !blocked;
    stat.div_done = div_done;
    stat.mul_done = mdone_r;
    stat.out_free = !out_valid_r || !out_stall;
  end

endmodule

[sv/dee_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences fraction scaling, the operation and the result load.
// Depends on dee_pkg.
module dee_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  input  dee_pkg::stat_t stat,
  output logic           in_stall,
  output dee_pkg::cmd_t  cmd
);
  import dee_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_F1_GO   = 3'd1;
  localparam logic [2:0] S_F1_WAIT = 3'd2;
  localparam logic [2:0] S_F2_GO   = 3'd3;
  localparam logic [2:0] S_F2_WAIT = 3'd4;
  localparam logic [2:0] S_OP_GO   = 3'd5;
  localparam logic [2:0] S_OP_WAIT = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = state_r != S_IDLE;
    case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && in_last) state_nxt = S_F1_GO;
      end
      S_F1_GO: begin
        if (stat.err) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start_div = 1'b1;
          cmd.div_src   = DS_FRAC1;
          state_nxt     = S_F1_WAIT;
        end
      end
      S_F1_WAIT: begin
        if (stat.div_done) begin
          cmd.load_frac1 = 1'b1;
          state_nxt      = S_F2_GO;
        end
      end
      S_F2_GO: begin
        cmd.start_div = 1'b1;
        cmd.div_src   = DS_FRAC2;
        state_nxt     = S_F2_WAIT;
      end
      S_F2_WAIT: begin
        if (stat.div_done) begin
          cmd.load_frac2 = 1'b1;
          state_nxt      = S_OP_GO;
        end
      end
      S_OP_GO: begin
        cmd.div_src = DS_OPER;
        if (stat.need_div) begin
          cmd.start_div = 1'b1;
          state_nxt     = S_OP_WAIT;
        end else if (stat.need_mul) begin
          cmd.start_mul = 1'b1;
          state_nxt     = S_OP_WAIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_OP_WAIT: begin
        if (stat.div_done || stat.mul_done) begin
          cmd.load_op = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
